FILE: hw/rtl/tet_pkg.sv
// ----------------------------------------------------------------------------
// tet_pkg: shared types and codes of the timer event table
// Item layouts, operation and status codes, and the per-tick result limit.
// ----------------------------------------------------------------------------
package tet_pkg;

    localparam int MAX_OUT = 16;
    localparam int TAG_W   = 16;
    localparam int SLOT_W  = 4;

    localparam logic [1:0] KIND_ONESHOT  = 2'd0;
    localparam logic [1:0] KIND_PERIODIC = 2'd1;
    localparam logic [1:0] KIND_CANCEL   = 2'd2;
    localparam logic [1:0] KIND_TICK     = 2'd3;

    localparam logic [2:0] STATUS_REGISTERED = 3'd0;
    localparam logic [2:0] STATUS_FULL       = 3'd1;
    localparam logic [2:0] STATUS_CANCELLED  = 3'd2;
    localparam logic [2:0] STATUS_NOT_FOUND  = 3'd3;
    localparam logic [2:0] STATUS_FIRED      = 3'd4;
    localparam logic [2:0] STATUS_NONE_DUE   = 3'd5;

    typedef struct packed {
        logic [1:0]        kind;
        logic [31:0]       deadline;
        logic [31:0]       period;
        logic [SLOT_W-1:0] handle;
        logic [TAG_W-1:0]  action_tag;
    } t_in_item;

    typedef struct packed {
        logic [2:0]        status;
        logic [SLOT_W-1:0] slot;
        logic [TAG_W-1:0]  fired_tag;
        logic              last;
    } t_out_item;

    // scan control from the sequencer to the selection unit
    typedef struct packed {
        logic clear;
        logic rd_vld;
        logic eligible;
    } t_scan_ctl;

endpackage

FILE: hw/rtl/timer_event_table.sv
// ----------------------------------------------------------------------------
// timer_event_table: table of one-shot and periodic timer slots
// Register, cancel and tick items; a tick fires every due slot, most overdue
// first, ties to the lower slot, at most MAX_OUT firings per tick.
// ----------------------------------------------------------------------------
// register / cancel: result in the cycle after accept, busy stays low (1 item/cycle)
// tick: one scan pass per firing plus a final pass that finds none; when MAX_OUT
//   fire, a flush state replaces that final pass; a fired result is held until
//   the next pass shows whether it is the final one and leaves the cycle after
// the scan rate is one slot per cycle, set by the single slot-memory read port
// results are one-cycle strobes on o_res_valid; the receiver cannot stall
// synchronous active-low reset frees every slot and zeroes the tick counter
module timer_event_table
    import tet_pkg::*;
#(
    parameter int TIMER_SLOTS = 16,
    parameter int TIME_BITS   = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    input  t_in_item  i_item,
    output logic      busy,
    output logic      o_res_valid,
    output t_out_item o_result
);

    localparam int AW = $clog2(TIMER_SLOTS);
    localparam int TW = TIME_BITS;
    localparam int DW = 2 * TW + TAG_W + 1;
    localparam int CW = $clog2(MAX_OUT + 1);

    // word layout: deadline | period | periodic | tag
    localparam int DL_HI  = DW - 1;
    localparam int PER_HI = DW - TW - 1;
    localparam int PC_BIT = TAG_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_EVAL  = 3'd3;
    localparam logic [2:0] S_FLUSH = 3'd4;

    // control state
    logic [2:0]             r_state, n_state;
    logic [TW-1:0]          r_tick, n_tick;
    logic [TIMER_SLOTS-1:0] r_valid, n_valid;
    logic [TIMER_SLOTS-1:0] r_picked, n_picked;
    logic [AW-1:0]          r_addr, n_addr;
    logic                   r_rd_vld;
    logic [CW-1:0]          r_cnt, n_cnt;
    logic                   r_res_valid, n_res_valid;

    // payload
    logic                   r_rd_elig;
    logic [AW-1:0]          r_rd_idx;
    logic [AW-1:0]          r_pend_slot, n_pend_slot;
    logic [TAG_W-1:0]       r_pend_tag, n_pend_tag;
    t_out_item              r_res, n_res;

    // memory and selection unit
    logic                   s_we;
    logic [AW-1:0]          s_waddr;
    logic [DW-1:0]          s_wdata;
    logic [DW-1:0]          s_rdata;
    logic                   s_clr;
    t_scan_ctl              s_ctl;
    logic                   s_found;
    logic [AW-1:0]          s_best_idx;
    logic [DW-1:0]          s_best_word;

    // lowest free slot
    logic                   s_free_ok;
    logic [AW-1:0]          s_free_idx;

    logic                   s_accept;
    logic [TW-1:0]          s_in_dl;
    logic [TW-1:0]          s_in_per;
    logic [TW-1:0]          s_rearm_dl;

    assign s_accept = start && !busy;
    assign s_in_dl  = TW'(i_item.deadline);
    assign s_in_per = TW'(i_item.period);
    assign s_rearm_dl = s_best_word[DL_HI -: TW] + s_best_word[PER_HI -: TW];

    always_comb begin
        s_free_ok  = 1'b0;
        s_free_idx = '0;
        for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                s_free_ok  = 1'b1;
                s_free_idx = AW'(i);
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_tick      = r_tick;
        n_valid     = r_valid;
        n_picked    = r_picked;
        n_addr      = r_addr;
        n_cnt       = r_cnt;
        n_pend_slot = r_pend_slot;
        n_pend_tag  = r_pend_tag;
        n_res_valid = 1'b0;
        n_res       = '0;
        s_we        = 1'b0;
        s_waddr     = '0;
        s_wdata     = '0;
        s_clr       = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    case (i_item.kind)
                        KIND_ONESHOT, KIND_PERIODIC: begin
                            n_res_valid = 1'b1;
                            n_res.last  = 1'b1;
                            if (s_free_ok) begin
                                s_we    = 1'b1;
                                s_waddr = s_free_idx;
                                if (i_item.kind == KIND_PERIODIC) begin
                                    s_wdata = {r_tick + s_in_per, s_in_per, 1'b1,
                                               i_item.action_tag};
                                end else begin
                                    s_wdata = {s_in_dl, {TW{1'b0}}, 1'b0,
                                               i_item.action_tag};
                                end
                                n_valid[s_free_idx] = 1'b1;
                                n_res.status = STATUS_REGISTERED;
                                n_res.slot   = SLOT_W'(s_free_idx);
                            end else begin
                                n_res.status = STATUS_FULL;
                            end
                        end
                        KIND_CANCEL: begin
                            n_res_valid = 1'b1;
                            n_res.last  = 1'b1;
                            n_res.slot  = i_item.handle;
                            if ((int'(i_item.handle) < TIMER_SLOTS) &&
                                r_valid[AW'(i_item.handle)]) begin
                                n_valid[AW'(i_item.handle)] = 1'b0;
                                n_res.status = STATUS_CANCELLED;
                            end else begin
                                n_res.status = STATUS_NOT_FOUND;
                            end
                        end
                        default: begin
                            // tick: advance time, then scan with the new value
                            n_tick   = r_tick + 1'b1;
                            n_picked = '0;
                            n_addr   = '0;
                            n_cnt    = '0;
                            s_clr    = 1'b1;
                            n_state  = S_SCAN;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (r_addr == AW'(TIMER_SLOTS - 1)) begin
                    n_state = S_DRAIN;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            S_DRAIN: begin
                // last read of the pass is being compared this cycle
                n_state = S_EVAL;
            end
            S_EVAL: begin
                if (s_found) begin
                    // the held firing is not the final one
                    if (r_cnt != '0) begin
                        n_res_valid     = 1'b1;
                        n_res.status    = STATUS_FIRED;
                        n_res.slot      = SLOT_W'(r_pend_slot);
                        n_res.fired_tag = r_pend_tag;
                    end
                    n_pend_slot          = s_best_idx;
                    n_pend_tag           = s_best_word[TAG_W-1:0];
                    n_cnt                = r_cnt + 1'b1;
                    n_picked[s_best_idx] = 1'b1;
                    // re-arm or free now; picked slots are skipped for the rest
                    // of this tick so later passes are unaffected
                    if (s_best_word[PC_BIT]) begin
                        s_we    = 1'b1;
                        s_waddr = s_best_idx;
                        s_wdata = {s_rearm_dl, s_best_word[PER_HI:0]};
                    end else begin
                        n_valid[s_best_idx] = 1'b0;
                    end
                    if (r_cnt == CW'(MAX_OUT - 1)) begin
                        n_state = S_FLUSH;
                    end else begin
                        n_addr  = '0;
                        s_clr   = 1'b1;
                        n_state = S_SCAN;
                    end
                end else begin
                    n_res_valid = 1'b1;
                    n_res.last  = 1'b1;
                    if (r_cnt != '0) begin
                        n_res.status    = STATUS_FIRED;
                        n_res.slot      = SLOT_W'(r_pend_slot);
                        n_res.fired_tag = r_pend_tag;
                    end else begin
                        n_res.status = STATUS_NONE_DUE;
                    end
                    n_state = S_IDLE;
                end
            end
            S_FLUSH: begin
                n_res_valid     = 1'b1;
                n_res.status    = STATUS_FIRED;
                n_res.slot      = SLOT_W'(r_pend_slot);
                n_res.fired_tag = r_pend_tag;
                n_res.last      = 1'b1;
                n_state         = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tick      <= '0;
            r_valid     <= '0;
            r_picked    <= '0;
            r_addr      <= '0;
            r_rd_vld    <= 1'b0;
            r_cnt       <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_tick      <= n_tick;
            r_valid     <= n_valid;
            r_picked    <= n_picked;
            r_addr      <= n_addr;
            r_rd_vld    <= (r_state == S_SCAN);
            r_cnt       <= n_cnt;
            r_res_valid <= n_res_valid;
        end
    end

    // read side-band travels with the memory latency
    always_ff @(posedge i_clk) begin
        r_rd_elig   <= r_valid[r_addr] && !r_picked[r_addr];
        r_rd_idx    <= r_addr;
        r_pend_slot <= n_pend_slot;
        r_pend_tag  <= n_pend_tag;
        r_res       <= n_res;
    end

    assign s_ctl.clear    = s_clr;
    assign s_ctl.rd_vld   = r_rd_vld;
    assign s_ctl.eligible = r_rd_elig;

    tet_slot_ram #(
        .DEPTH  (TIMER_SLOTS),
        .DATA_W (DW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_raddr (r_addr),
        .o_rdata (s_rdata)
    );

    tet_sched #(
        .TIMER_SLOTS (TIMER_SLOTS),
        .TIME_BITS   (TIME_BITS)
    ) u_sched (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (s_ctl),
        .i_rd_idx  (r_rd_idx),
        .i_rd_data (s_rdata),
        .i_tick    (r_tick),
        .o_found   (s_found),
        .o_idx     (s_best_idx),
        .o_word    (s_best_word)
    );

    assign busy        = (r_state != S_IDLE);
    assign o_res_valid = r_res_valid;
    assign o_result    = r_res;

    // register and cancel answer with a single final result next cycle
    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && (i_item.kind != KIND_TICK)) |=> (o_res_valid && o_result.last))
        else $error("register/cancel result missing");

    // a non-final result only appears while a tick is still being worked
    a_mid_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !o_result.last) |-> busy)
        else $error("non-final result outside a tick");

    // firing count bounded by the per-tick limit
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_OUT))
        else $error("firing count overrun");

    // only fired results carry a tag
    a_tag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && (o_result.status != STATUS_FIRED)) |-> (o_result.fired_tag == '0))
        else $error("tag on non-fired result");

endmodule

FILE: hw/rtl/tet_slot_ram.sv
// ----------------------------------------------------------------------------
// tet_slot_ram: slot storage
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module tet_slot_ram #(
    parameter int DEPTH  = 16,
    parameter int DATA_W = 81
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_W-1:0]        i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/tet_sched.sv
// ----------------------------------------------------------------------------
// tet_sched: due-slot selection
// Tracks the most overdue eligible slot over one pass of reads, lower slot
// wins a tie since slots arrive in ascending order.
// ----------------------------------------------------------------------------
module tet_sched
    import tet_pkg::*;
#(
    parameter int TIMER_SLOTS = 16,
    parameter int TIME_BITS   = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  t_scan_ctl                      i_ctl,
    input  logic [$clog2(TIMER_SLOTS)-1:0] i_rd_idx,
    input  logic [2*TIME_BITS+TAG_W:0]     i_rd_data,
    input  logic [TIME_BITS-1:0]           i_tick,
    output logic                           o_found,
    output logic [$clog2(TIMER_SLOTS)-1:0] o_idx,
    output logic [2*TIME_BITS+TAG_W:0]     o_word
);

    localparam int AW = $clog2(TIMER_SLOTS);
    localparam int TW = TIME_BITS;
    localparam int DW = 2 * TW + TAG_W + 1;

    logic          r_found;
    logic [AW-1:0] r_idx;
    logic [TW-1:0] r_d;
    logic [DW-1:0] r_word;

    logic [TW-1:0] s_d;
    logic          s_take;

    // overdue amount, wrapped; msb set means not yet due
    assign s_d    = i_tick - i_rd_data[DW-1 -: TW];
    assign s_take = i_ctl.rd_vld && i_ctl.eligible && !s_d[TW-1] &&
                    (!r_found || (s_d > r_d));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_ctl.clear) begin
            r_found <= 1'b0;
        end else if (s_take) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_take) begin
            r_idx  <= i_rd_idx;
            r_d    <= s_d;
            r_word <= i_rd_data;
        end
    end

    assign o_found = r_found;
    assign o_idx   = r_idx;
    assign o_word  = r_word;

endmodule
